// File: rtl/kfst_pkg.sv
// ----------------------------------------------------------------------------
// kfst_pkg
// shared widths, command codes and the sweep write record of the slot tree
// ----------------------------------------------------------------------------
package kfst_pkg;

    localparam int SLOTS   = 1024;
    localparam int IDX_W   = 10;              // slot index bits
    localparam int NODE_W  = IDX_W + 1;       // heap node address bits
    localparam int CNT_W   = IDX_W + 1;       // free count bits, holds SLOTS
    localparam int VAL_W   = 15;
    localparam int CMD_W   = 2;

    localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
    localparam logic [NODE_W-1:0] LAST_NODE = {NODE_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PLACE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // one tree write from the clearing sweep
    typedef struct packed {
        logic              en;
        logic              last;
        logic [NODE_W-1:0] addr;
        logic [CNT_W-1:0]  count;
    } t_sweep_wr;

endpackage

// File: rtl/kfst_sweep.sv
// ----------------------------------------------------------------------------
// kfst_sweep
// walks every tree node once and gives the free count a fresh clear leaves it
// ----------------------------------------------------------------------------
module kfst_sweep (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [kfst_pkg::CNT_W-1:0] i_size,
    output kfst_pkg::t_sweep_wr    o_wr
);
    import kfst_pkg::*;

    logic              r_active;
    logic [NODE_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_lo;     // first slot under the node
    logic [CNT_W-1:0]  r_span;   // slots under one node of this level
    logic [CNT_W-1:0]  r_size;

    logic [CNT_W-1:0]  w_diff;
    logic [CNT_W-1:0]  w_next_lo;

    assign w_diff    = r_size - r_lo;
    assign w_next_lo = r_lo + r_span;

    always_comb begin
        o_wr.en    = r_active;
        o_wr.last  = r_active && (r_addr == LAST_NODE);
        o_wr.addr  = r_addr;
        if (r_size <= r_lo) begin
            o_wr.count = '0;
        end else if (w_diff >= r_span) begin
            o_wr.count = r_span;
        end else begin
            o_wr.count = w_diff;
        end
    end

    // reset starts a sweep on its own, with the full row free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_addr   <= NODE_W'(1);
            r_lo     <= '0;
            r_span   <= SLOTS_CNT;
            r_size   <= SLOTS_CNT;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_addr   <= NODE_W'(1);
            r_lo     <= '0;
            r_span   <= SLOTS_CNT;
            r_size   <= i_size;
        end else if (r_active) begin
            if (r_addr == LAST_NODE) begin
                r_active <= 1'b0;
            end else begin
                r_addr <= r_addr + NODE_W'(1);
                // end of a level: next level starts at slot zero, half span
                if (w_next_lo == SLOTS_CNT) begin
                    r_lo   <= '0;
                    r_span <= r_span >> 1;
                end else begin
                    r_lo <= w_next_lo;
                end
            end
        end
    end

endmodule

// File: rtl/kth_free_slot_tree.sv
// ----------------------------------------------------------------------------
// kth_free_slot_tree
// count tree over a row of slots: clear, place at the k-th free slot, read
// ----------------------------------------------------------------------------
// usage
//   command channel: an item is taken at a clock edge with start high and busy
//   low; fields are i_command, i_rank, i_value, i_slot_index
//   result channel: one result per item, valid for one cycle while o_strobe is
//   high; the receiver cannot stall, so the result must be taken that cycle
//   config: i_cfg_we writes i_slots_in_use; it takes effect at the next clear
// timing (from the accepting edge to the edge that loads the result)
//   failed place or unknown command: result loaded at the accepting edge
//   read: bound by the slot memory read latency
//   place: one read-modify-write of the count memory per tree level
//   clear: one count memory node written per cycle
//   a new item can be accepted in the cycle after the result is loaded
// reset
//   reset starts the same sweep with all 1024 slots free; busy is
//   high during it and no result is given for it
// ----------------------------------------------------------------------------
module kth_free_slot_tree (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [kfst_pkg::CMD_W-1:0]   i_command,
    input  logic [kfst_pkg::CNT_W-1:0]   i_rank,
    input  logic [kfst_pkg::VAL_W-1:0]   i_value,
    input  logic [kfst_pkg::IDX_W-1:0]   i_slot_index,
    input  logic                         i_cfg_we,
    input  logic [kfst_pkg::CNT_W-1:0]   i_slots_in_use,
    output logic                         o_strobe,
    output logic [kfst_pkg::IDX_W-1:0]   o_found_slot,
    output logic [kfst_pkg::VAL_W-1:0]   o_read_value,
    output logic                         o_occupied,
    output logic                         o_error,
    output logic [kfst_pkg::CNT_W-1:0]   o_free_count
);
    import kfst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SWEEP   = 4'b0010,
        S_DESCEND = 4'b0100,
        S_READ    = 4'b1000
    } t_state;

    localparam int NODES = 1 << NODE_W;

    // count memory: heap layout, root at node 1, leaves at SLOTS .. 2*SLOTS-1
    logic [CNT_W-1:0]       r_tree_mem [NODES];
    logic [CNT_W-1:0]       r_tree_q;
    // slot memory: {taken, value}
    logic [VAL_W:0]         r_slot_mem [SLOTS];
    logic [VAL_W:0]         r_slot_q;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cfg_size;
    logic [CNT_W-1:0]       r_free_total, n_free_total;
    logic                   r_report, n_report;   // clear sweep owes a result
    logic [NODE_W-1:0]      r_node, n_node;       // node whose left child is read
    logic [CNT_W-1:0]       r_rem, n_rem;         // rank left inside r_node
    logic [CNT_W-1:0]       r_par, n_par;         // free count of r_node
    logic [VAL_W-1:0]       r_value;
    logic [IDX_W-1:0]       r_idx;

    logic                   n_strobe;
    logic [IDX_W-1:0]       n_found;
    logic [VAL_W-1:0]       n_rval;
    logic                   n_occ;
    logic                   n_err;
    logic [CNT_W-1:0]       n_fcount;

    logic                   w_accept;
    logic [CNT_W-1:0]       w_eff_size;
    logic                   w_sweep_start;
    t_sweep_wr              w_sweep;

    logic                   w_tree_we, w_tree_re;
    logic [NODE_W-1:0]      w_tree_waddr, w_tree_raddr;
    logic [CNT_W-1:0]       w_tree_wdata;
    logic                   w_slot_we, w_slot_re;
    logic [IDX_W-1:0]       w_slot_waddr;
    logic [VAL_W:0]         w_slot_wdata;

    // descent step
    logic                   w_go_left;
    logic [NODE_W-1:0]      w_child;
    logic [CNT_W-1:0]       w_right;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // size actually cleared: zero acts as one, above the row acts as the row
    always_comb begin
        if (r_cfg_size == '0) begin
            w_eff_size = CNT_W'(1);
        end else if (r_cfg_size > SLOTS_CNT) begin
            w_eff_size = SLOTS_CNT;
        end else begin
            w_eff_size = r_cfg_size;
        end
    end

    kfst_sweep u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sweep_start),
        .i_size  (w_eff_size),
        .o_wr    (w_sweep)
    );

    // left child count came back; choose a side and lower the chosen child
    assign w_go_left = (r_rem <= r_tree_q);
    assign w_right   = r_par - r_tree_q;
    assign w_child   = {r_node[NODE_W-2:0], !w_go_left};

    always_comb begin
        n_state       = r_state;
        n_free_total  = r_free_total;
        n_report      = r_report;
        n_node        = r_node;
        n_rem         = r_rem;
        n_par         = r_par;
        n_strobe      = 1'b0;
        n_found       = '0;
        n_rval        = '0;
        n_occ         = 1'b0;
        n_err         = 1'b0;
        n_fcount      = r_free_total;
        w_sweep_start = 1'b0;
        w_tree_we     = 1'b0;
        w_tree_waddr  = w_sweep.addr;
        w_tree_wdata  = w_sweep.count;
        w_tree_re     = 1'b0;
        w_tree_raddr  = NODE_W'(2);
        w_slot_we     = 1'b0;
        w_slot_waddr  = w_sweep.addr[IDX_W-1:0];
        w_slot_wdata  = '0;
        w_slot_re     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_command)
                        CMD_CLEAR: begin
                            w_sweep_start = 1'b1;
                            n_free_total  = w_eff_size;
                            n_report      = 1'b1;
                            n_state       = S_SWEEP;
                        end
                        CMD_PLACE: begin
                            if (i_rank == '0 || i_rank > r_free_total) begin
                                n_strobe = 1'b1;
                                n_err    = 1'b1;
                            end else begin
                                // start at the root, whose count is the total
                                w_tree_re    = 1'b1;
                                w_tree_raddr = NODE_W'(2);
                                n_node       = NODE_W'(1);
                                n_rem        = i_rank;
                                n_par        = r_free_total;
                                n_state      = S_DESCEND;
                            end
                        end
                        CMD_READ: begin
                            w_slot_re = 1'b1;
                            n_state   = S_READ;
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_err    = 1'b1;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                w_tree_we = w_sweep.en;
                w_slot_we = w_sweep.en;
                if (w_sweep.last) begin
                    n_state  = S_IDLE;
                    n_report = 1'b0;
                    n_strobe = r_report;
                end
            end
            S_DESCEND: begin
                // the written child is never the node read in the same cycle
                w_tree_we    = 1'b1;
                w_tree_waddr = w_child;
                n_node       = w_child;
                if (w_go_left) begin
                    w_tree_wdata = r_tree_q - CNT_W'(1);
                    n_par        = r_tree_q;
                end else begin
                    w_tree_wdata = w_right - CNT_W'(1);
                    n_par        = w_right;
                    n_rem        = r_rem - r_tree_q;
                end
                if (w_child[NODE_W-1]) begin
                    // reached a leaf: the slot is the leaf offset
                    w_slot_we    = 1'b1;
                    w_slot_waddr = w_child[IDX_W-1:0];
                    w_slot_wdata = {1'b1, r_value};
                    n_free_total = r_free_total - CNT_W'(1);
                    n_strobe     = 1'b1;
                    n_found      = w_child[IDX_W-1:0];
                    n_fcount     = r_free_total - CNT_W'(1);
                    n_state      = S_IDLE;
                end else begin
                    w_tree_re    = 1'b1;
                    w_tree_raddr = {w_child[NODE_W-2:0], 1'b0};
                end
            end
            S_READ: begin
                n_strobe = 1'b1;
                n_found  = r_idx;
                n_occ    = r_slot_q[VAL_W];
                n_rval   = r_slot_q[VAL_W] ? r_slot_q[VAL_W-1:0] : '0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // count memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_tree_we) begin
            r_tree_mem[w_tree_waddr] <= w_tree_wdata;
        end
        if (w_tree_re) begin
            r_tree_q <= r_tree_mem[w_tree_raddr];
        end
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_slot_mem[w_slot_waddr] <= w_slot_wdata;
        end
        if (w_slot_re) begin
            r_slot_q <= r_slot_mem[i_slot_index];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_free_total <= SLOTS_CNT;
            r_report     <= 1'b0;
            r_cfg_size   <= SLOTS_CNT;
            o_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_total <= n_free_total;
            r_report     <= n_report;
            o_strobe     <= n_strobe;
            if (i_cfg_we) begin
                r_cfg_size <= i_slots_in_use;
            end
        end
    end

    // item and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_rem  <= n_rem;
        r_par  <= n_par;
        if (w_accept) begin
            r_value <= i_value;
            r_idx   <= i_slot_index;
        end
        if (n_strobe) begin
            o_found_slot <= n_found;
            o_read_value <= n_rval;
            o_occupied   <= n_occ;
            o_error      <= n_err;
            o_free_count <= n_fcount;
        end
    end

`ifndef SYNTHESIS
    // the sweep owns the count memory only while the block waits on it
    a_sweep_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sweep.en |-> (r_state == S_SWEEP))
        else $error("sweep running outside the sweep state");

    // the rank left always lies inside the node being descended
    a_rank_in_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DESCEND) |-> (r_rem != '0 && r_rem <= r_par))
        else $error("descent lost its rank");

    // the free total never exceeds the row
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_total <= SLOTS_CNT)
        else $error("free total above row size");

    // a read item gives its result once its slot memory read and the result register have been passed
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command == CMD_READ) |=> ##1 o_strobe)
        else $error("read result missing");
`endif

endmodule
